/* rtl/rclfd_pkg.sv */
`default_nettype none

package rclfd_pkg;

  // Fields of one received word of the link stream.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_start;
  } link_word_t;

  // Fields of one decoded channel word.
  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_channel;
  } chan_word_t;

  localparam int          PAYLOAD_BYTES  = 22;
  localparam int          CHAN_W         = 11;
  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [7:0]  GOOD_LENGTH    = 8'd24;
  localparam logic [7:0]  DEV_ADDR_RESET = 8'd200;

  // Frame position codes.
  localparam logic [4:0] POS_IDLE   = 5'd0;
  localparam logic [4:0] POS_LENGTH = 5'd1;
  localparam logic [4:0] POS_TYPE   = 5'd2;
  localparam logic [4:0] POS_DATA   = 5'd3;
  localparam logic [4:0] POS_CRC    = 5'd25;

  // Register indexes of the configuration port.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  // One CRC-8 update, MSB first.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/rclfd_ram.sv */
`default_nettype none

module rclfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rc_link_frame_channel_decoder_unit.sv */
`default_nettype none

// Throughput: one link word per cycle. A burst ends before the next frame's CRC word can
// arrive, so the input stalls on a CRC word only while a held-off burst is still pending.
// After a good CRC word is taken, payload bytes are read from the memory into the bit buffer and
// eleven-bit channel words are popped into the output register, NUM_CHANNELS words per frame.
// Reset clears all control state and sets device_address to 0xC8; the payload memory is not cleared.
module rc_link_frame_channel_decoder_unit #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Link word channel.
  input  wire logic                link_valid,
  output logic                     link_ready,
  input  wire rclfd_pkg::link_word_t link_word,
  // Channel word channel.
  output logic                     chan_valid,
  input  wire logic                chan_ready,
  output rclfd_pkg::chan_word_t    chan_word,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import rclfd_pkg::*;

  // The payload memory holds two banks of one frame each. A frame is written into
  // the write bank; when it passes its checks the banks swap, so the next frame can
  // fill while the finished one is unpacked from the other bank.
  localparam int MEM_DEPTH    = 2 * PAYLOAD_BYTES;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int BYTES_NEEDED = (NUM_CHANNELS * CHAN_W + 7) / 8;
  // The bit buffer holds a partial channel plus two bytes, so a payload read can
  // be issued every cycle while the receiver keeps up.
  localparam int ACC_W        = CHAN_W + 15;

  // Configuration register.
  logic [7:0] device_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_ADDRESS) begin
      device_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEVICE_ADDRESS) begin
      prdata = {24'd0, device_address};
    end
  end

  // Frame parser state.
  logic [4:0] frame_position;
  logic [7:0] declared_length;
  logic [7:0] running_crc;
  logic       wbank;

  // Unpacker state.
  logic             emit_busy;
  logic             rbank;
  logic [4:0]       rd_idx;
  logic             rd_pending;
  logic [ACC_W-1:0] acc;
  logic [4:0]       acc_cnt;
  logic [4:0]       chan;

  logic link_fire;
  logic frame_good;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0] mem_rdata;
  logic [4:0] data_idx;

  // A CRC word may start a new burst, so it waits while a burst is running.
  assign link_ready = !(emit_busy && frame_position == POS_CRC);
  assign link_fire  = link_valid && link_ready;

  assign frame_good = link_fire && !link_word.chunk_start && frame_position == POS_CRC &&
                      declared_length == GOOD_LENGTH && running_crc == link_word.rx_byte;

  assign data_idx  = frame_position - POS_DATA;
  assign mem_we    = link_fire && !link_word.chunk_start &&
                     frame_position >= POS_DATA && frame_position < POS_CRC;
  assign mem_waddr = wbank ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(data_idx) : ADDR_W'(data_idx);
  assign mem_raddr = rbank ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= POS_IDLE;
      declared_length <= '0;
      running_crc     <= '0;
    end else if (link_fire) begin
      if (link_word.chunk_start) begin
        // A chunk start always ends the frame in progress.
        frame_position <= (link_word.rx_byte == device_address) ? POS_LENGTH : POS_IDLE;
        running_crc    <= '0;
      end else if (frame_position == POS_IDLE || frame_position > POS_CRC) begin
        frame_position <= POS_IDLE;
      end else if (frame_position == POS_LENGTH) begin
        declared_length <= link_word.rx_byte;
        running_crc     <= '0;
        frame_position  <= POS_TYPE;
      end else if (frame_position < POS_CRC) begin
        running_crc    <= crc_fold(running_crc, link_word.rx_byte);
        frame_position <= frame_position + 5'd1;
      end else begin
        frame_position <= POS_IDLE;
      end
    end
  end

  rclfd_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_payload_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(link_word.rx_byte),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // The unpacker streams payload bytes into a little-endian bit buffer and pops
  // eleven bits into the output register whenever enough bits are present and it is free.
  logic             out_free;
  logic             emit_go;
  logic [ACC_W-1:0] acc_after;
  logic [4:0]       cnt_after;
  logic [ACC_W-1:0] acc_next;
  logic [4:0]       acc_cnt_next;
  logic             issue;

  assign out_free = !chan_valid || chan_ready;
  assign emit_go  = emit_busy && acc_cnt >= 5'(CHAN_W) && out_free;

  always_comb begin
    acc_after    = emit_go ? (acc >> CHAN_W) : acc;
    cnt_after    = emit_go ? acc_cnt - 5'(CHAN_W) : acc_cnt;
    acc_next     = acc_after;
    acc_cnt_next = cnt_after;
    if (rd_pending) begin
      acc_next     = acc_after | (ACC_W'(mem_rdata) << cnt_after);
      acc_cnt_next = cnt_after + 5'd8;
    end
  end

  // A read is issued only when the byte it returns still fits in the buffer.
  assign issue = emit_busy && rd_idx < 5'(BYTES_NEEDED) && acc_cnt_next <= 5'(ACC_W - 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      wbank      <= 1'b0;
      rbank      <= 1'b0;
      emit_busy  <= 1'b0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
      acc        <= '0;
      acc_cnt    <= '0;
      chan       <= '0;
    end else if (frame_good) begin
      wbank      <= !wbank;
      rbank      <= wbank;
      emit_busy  <= 1'b1;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
      acc        <= '0;
      acc_cnt    <= '0;
      chan       <= '0;
    end else begin
      acc        <= acc_next;
      acc_cnt    <= acc_cnt_next;
      rd_pending <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 5'd1;
      end
      if (emit_go) begin
        chan <= chan + 5'd1;
        if (chan == 5'(NUM_CHANNELS - 1)) begin
          emit_busy <= 1'b0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= 1'b0;
    end else if (emit_go) begin
      chan_valid <= 1'b1;
    end else if (chan_ready) begin
      chan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      chan_word.channel_index <= chan[3:0];
      chan_word.channel_value <= acc[CHAN_W-1:0];
      chan_word.last_channel  <= (chan == 5'(NUM_CHANNELS - 1));
    end
  end

endmodule

`default_nettype wire

/* bench/rc_link_frame_channel_decoder_unit_test.sv */
`timescale 1ns / 1ps

module rc_link_frame_channel_decoder_unit_test;
  import rclfd_pkg::*;

  // Sixteen channels per frame, as the link carries them.
  localparam int CHANNELS = 16;
  // Address byte, length byte, type byte, payload and CRC byte.
  localparam int FRAME_WORDS = PAYLOAD_BYTES + 4;
  // Byte addresses on the configuration port: one register, then nothing.
  localparam logic [2:0] ADDR_DEVICE = 3'(REG_DEVICE_ADDRESS) << 2;
  localparam logic [2:0] ADDR_PAST_END = 3'd4;
  // Cycles to let a frame that ends in a drop settle.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  // Length of the one long receiver hold-off.
  localparam int LONG_HOLD = 400;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic link_valid = 1'b0;
  logic link_ready;
  link_word_t link_word = '0;

  logic chan_valid;
  logic chan_ready = 1'b0;
  chan_word_t chan_word;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  rc_link_frame_channel_decoder_unit #(
    .NUM_CHANNELS(CHANNELS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .link_valid(link_valid),
    .link_ready(link_ready),
    .link_word(link_word),
    .chan_valid(chan_valid),
    .chan_ready(chan_ready),
    .chan_word(chan_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Words waiting to be offered on the link channel, and channel words that
  // the decoder is predicted to produce, oldest first.
  link_word_t link_backlog[$];
  chan_word_t pending_chan_words[$];

  // Shadow of the decoder: the address setting and the frame parser state.
  logic [7:0] addr_setting = DEV_ADDR_RESET;
  logic [4:0] rx_pos = POS_IDLE;
  logic [7:0] rx_len = '0;
  logic [7:0] rx_crc = '0;
  logic [7:0] rx_payload[PAYLOAD_BYTES];

  // Idling control. Both sides idle in bursts while bursty is set; the tail of
  // the run clears it so that the last words stream at full rate.
  logic bursty = 1'b1;
  logic want_long_hold = 1'b0;
  logic long_hold_done = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  int words_queued = 0;
  int good_frames_queued = 0;
  int words_checked = 0;
  int addr_settings = 1;
  int fail_count = 0;
  int quiet_cycles = 0;

  // CRC-8 with polynomial 0xD5, folding the data one bit at a time, MSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Advances the shadow parser by one accepted link word. A good CRC word
  // queues the sixteen channel words unpacked from the stored payload: channel
  // k is payload bits 11k up to 11k+10, counted from bit 0 of the first byte.
  function automatic void decode_link_word(input link_word_t w);
    logic [8*PAYLOAD_BYTES-1:0] flat;
    chan_word_t cw;
    if (w.chunk_start) begin
      // A chunk start always ends the frame in progress.
      rx_pos = (w.rx_byte == addr_setting) ? POS_LENGTH : POS_IDLE;
      rx_crc = '0;
    end else if (rx_pos == POS_IDLE || rx_pos > POS_CRC) begin
      rx_pos = POS_IDLE;
    end else if (rx_pos == POS_LENGTH) begin
      rx_len = w.rx_byte;
      rx_crc = '0;
      rx_pos = POS_TYPE;
    end else if (rx_pos < POS_CRC) begin
      rx_crc = crc8_next(rx_crc, w.rx_byte);
      if (rx_pos >= POS_DATA) begin
        rx_payload[rx_pos - POS_DATA] = w.rx_byte;
      end
      rx_pos = rx_pos + 5'd1;
    end else begin
      // The length must be right as well as the CRC; anything else is dropped.
      if (rx_len == GOOD_LENGTH && rx_crc == w.rx_byte) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          flat[8*i +: 8] = rx_payload[i];
        end
        for (int k = 0; k < CHANNELS; k++) begin
          cw.channel_index = 4'(k);
          cw.channel_value = flat[CHAN_W*k +: CHAN_W];
          cw.last_channel = (k == CHANNELS - 1);
          pending_chan_words.push_back(cw);
        end
      end
      rx_pos = POS_IDLE;
    end
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Link driver. The shadow parser is advanced at the edge where a word is
  // taken, so predictions always line up with what the decoder has seen.
  always @(posedge clk) begin : feed_link
    logic taken;
    taken = link_valid && link_ready;
    if (taken) begin
      decode_link_word(link_word);
    end
    if (rst) begin
      link_valid <= 1'b0;
      gap_left <= 0;
    end else if (!link_valid || taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        link_valid <= 1'b0;
      end else if (bursty && link_backlog.size() != 0 && $urandom_range(0, 11) == 0) begin
        // Start an idle gap on the link, this cycle included.
        gap_left <= $urandom_range(0, 9);
        link_valid <= 1'b0;
      end else if (link_backlog.size() != 0) begin
        link_word <= link_backlog.pop_front();
        link_valid <= 1'b1;
      end else begin
        link_valid <= 1'b0;
      end
    end
  end

  // Channel monitor. Every channel word taken is matched against the oldest
  // prediction. The receiver stalls in short random bursts, and once for a
  // long stretch so that bursts pile up inside the decoder and its link
  // input has to stall on a CRC word.
  always @(posedge clk) begin : watch_chan
    chan_word_t want;
    if (chan_valid && chan_ready) begin
      words_checked++;
      if (pending_chan_words.size() == 0) begin
        $error("channel word with nothing predicted: index %0d, value %0d, last %0b",
               chan_word.channel_index, chan_word.channel_value, chan_word.last_channel);
        fail_count++;
      end else begin
        want = pending_chan_words.pop_front();
        check_field("channel_index", 11'(want.channel_index), 11'(chan_word.channel_index));
        check_field("channel_value", want.channel_value, chan_word.channel_value);
        check_field("last_channel", 11'(want.last_channel), 11'(chan_word.last_channel));
      end
    end
    if (rst) begin
      chan_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      chan_ready <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      hold_left <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
      chan_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      chan_ready <= 1'b0;
    end else if (bursty && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      chan_ready <= 1'b0;
    end else begin
      chan_ready <= 1'b1;
    end
  end

  // Watchdog: a correct decoder always moves a word on one of the channels
  // well within the limit, even across the long hold-off.
  always @(posedge clk) begin : hang_watch
    if (rst || (link_valid && link_ready) || (chan_valid && chan_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic start);
    link_word_t w;
    w.rx_byte = b;
    w.chunk_start = start;
    link_backlog.push_back(w);
    words_queued++;
  endtask

  // Queues one frame for the current address. Only the first keep words go
  // out, so a short keep leaves a frame that the next chunk start cuts off.
  task automatic queue_frame(input logic [7:0] len, input int keep, input bit spoil_crc,
                             input fill_e fill);
    logic [7:0] frame[FRAME_WORDS];
    logic [7:0] sum;
    frame[0] = addr_setting;
    frame[1] = len;
    sum = '0;
    for (int i = 2; i < FRAME_WORDS - 1; i++) begin
      case (fill)
        FILL_ZERO: frame[i] = 8'h00;
        FILL_ONES: frame[i] = 8'hFF;
        default:   frame[i] = 8'($urandom_range(0, 255));
      endcase
      sum = crc8_next(sum, frame[i]);
    end
    frame[FRAME_WORDS - 1] = spoil_crc ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
    if (len == GOOD_LENGTH && !spoil_crc && keep == FRAME_WORDS) begin
      good_frames_queued++;
    end
    for (int i = 0; i < keep; i++) begin
      push_word(frame[i], i == 0);
    end
  endtask

  // Loose bytes; about one in four is flagged as a chunk start, which may
  // happen to match the address and open a frame of its own.
  task automatic queue_noise(input int count);
    for (int i = 0; i < count; i++) begin
      push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Mostly well-formed frames with random payloads, mixed with spoiled CRCs,
  // wrong lengths, cut-off frames and noise.
  task automatic queue_traffic(input int count);
    int stop_at;
    int pick;
    logic [7:0] len;
    fill_e fill;
    stop_at = words_queued + count;
    while (words_queued < stop_at) begin
      pick = $urandom_range(0, 19);
      case ($urandom_range(0, 7))
        0:       fill = FILL_ZERO;
        1:       fill = FILL_ONES;
        default: fill = FILL_RANDOM;
      endcase
      if (pick < 11) begin
        queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, fill);
      end else if (pick < 13) begin
        queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b1, fill);
      end else if (pick < 15) begin
        len = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
              ($urandom_range(0, 1) ? 8'h00 : 8'hFF);
        if (len == GOOD_LENGTH) begin
          len = GOOD_LENGTH + 8'd1;
        end
        queue_frame(len, FRAME_WORDS, 1'b0, FILL_RANDOM);
      end else if (pick < 17) begin
        queue_frame(GOOD_LENGTH, $urandom_range(1, FRAME_WORDS - 1), 1'b0, FILL_RANDOM);
      end else begin
        queue_noise($urandom_range(1, 6));
      end
    end
  endtask

  // Waits until every queued word is taken and every predicted channel word
  // has come out, then lets a frame that ended in a drop settle.
  task automatic drain_all;
    while (link_backlog.size() != 0 || link_valid || pending_chan_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that ends at the edge
  // where the register takes the value.
  task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_DEVICE) begin
      addr_setting = data[7:0];
      addr_settings++;
    end
  endtask

  initial begin : run_test
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset address. First loose bytes: a matching byte
    // that is not a chunk start is ignored while idle, and a chunk start with
    // the wrong address leaves the decoder idle.
    push_word(DEV_ADDR_RESET, 1'b0);
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b0);
    // Payload all ones gives every channel 2047.
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, FILL_ONES);
    // A frame cut off midway by the chunk start of the next one.
    queue_frame(GOOD_LENGTH, 12, 1'b0, FILL_RANDOM);
    // Payload all zero gives every channel 0.
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, FILL_ZERO);
    // A wrong length still runs the whole frame and is then dropped.
    queue_frame(8'h00, FRAME_WORDS, 1'b0, FILL_RANDOM);
    // A CRC that does not match drops the frame.
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b1, FILL_RANDOM);
    // A frame cut off by a chunk start with the wrong address.
    queue_frame(GOOD_LENGTH, 5, 1'b0, FILL_RANDOM);
    push_word(~DEV_ADDR_RESET, 1'b1);
    push_word(8'h55, 1'b0);
    drain_all();

    // Lowest address. The receiver holds off for a long stretch while good
    // frames keep coming, so the decoder backs up and stalls its link input.
    set_register(ADDR_DEVICE, 32'h0000_0000);
    want_long_hold <= 1'b1;
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, FILL_RANDOM);
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, FILL_RANDOM);
    queue_frame(GOOD_LENGTH, FRAME_WORDS, 1'b0, FILL_RANDOM);
    drain_all();

    // Highest address, with the sender stopping midway until every channel
    // word predicted so far has come out.
    set_register(ADDR_DEVICE, 32'h0000_00FF);
    queue_traffic(10);
    drain_all();
    queue_traffic(10);
    drain_all();

    // A write past the last register must leave the address alone.
    set_register(ADDR_PAST_END, $urandom());
    queue_traffic(10);
    drain_all();

    // A random address, and the tail of the run with no idling at all.
    set_register(ADDR_DEVICE, 32'($urandom_range(0, 255)));
    bursty <= 1'b0;
    queue_traffic(20);
    drain_all();

    $display("Sent %0d link words holding %0d good frames under %0d address settings.",
             words_queued, good_frames_queued, addr_settings);
    $display("Checked %0d channel words, with %0d failures.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
